[rtl/lia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_pkg: shared types and constants for the line input assembler
// Character codes, phase encoding, result/state structs and the limit cap.
// ----------------------------------------------------------------------------
package lia_pkg;

  localparam int unsigned BUF_DEPTH_DEF = 64;
  localparam int unsigned IDX_W         = 7;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned TDATA_W       = 24;

  localparam logic [BYTE_W-1:0] CH_BANG = 8'h21;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS   = 8'h08;

  localparam logic [IDX_W-1:0] BUTTON_LEN      = 7'd4;
  localparam logic [IDX_W-1:0] LINE_LIMIT_RST  = 7'd64;
  localparam logic [IDX_W-1:0] IDX_MAX         = 7'd127;

  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_TEXT   = 2'd1,
    PH_BUTTON = 2'd2
  } lia_phase_t;

  typedef struct packed {
    logic              write_enable;
    logic [IDX_W-1:0]  write_index;
    logic [BYTE_W-1:0] write_data;
    logic              echo_backspace;
    logic              message_done;
    logic              message_kind;
    logic [IDX_W-1:0]  message_length;
  } lia_result_t;

  typedef struct packed {
    lia_phase_t       phase;
    logic [IDX_W-1:0] kept_count;
  } lia_state_t;

  // Highest usable line limit: buffer depth, capped so the terminator fits.
  function automatic logic [IDX_W-1:0] limit_cap(input int unsigned depth);
    logic [IDX_W-1:0] cap;
    if (depth > 127) begin
      cap = IDX_MAX;
    end else begin
      cap = IDX_W'(depth);
    end
    return cap;
  endfunction

endpackage

[rtl/lia_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_step: per-byte decode
// Computes the next phase/count and the write command for one received byte.
// ----------------------------------------------------------------------------
module lia_step #(
  parameter int unsigned BUF_DEPTH = lia_pkg::BUF_DEPTH_DEF
) (
  input  lia_pkg::lia_state_t              state,
  input  logic [lia_pkg::IDX_W-1:0]        line_limit,
  input  logic [lia_pkg::BYTE_W-1:0]       rx_byte,
  output lia_pkg::lia_state_t              state_next,
  output lia_pkg::lia_result_t             result
);

  localparam logic [lia_pkg::IDX_W-1:0] LIMIT_CAP = lia_pkg::limit_cap(BUF_DEPTH);

  logic [lia_pkg::IDX_W-1:0] eff_limit;
  logic [lia_pkg::IDX_W-1:0] kept_inc;
  logic                      in_text;   // byte belongs to a text line
  logic [lia_pkg::IDX_W-1:0] text_kept; // count seen by a text-line byte

  assign eff_limit = (line_limit > LIMIT_CAP) ? LIMIT_CAP : line_limit;
  assign kept_inc  = state.kept_count + 7'd1;
  assign in_text   = (state.phase == lia_pkg::PH_TEXT) || (rx_byte != lia_pkg::CH_BANG);
  assign text_kept = (state.phase == lia_pkg::PH_TEXT) ? state.kept_count : '0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state.phase)
      lia_pkg::PH_BUTTON: begin
        if (state.kept_count >= lia_pkg::BUTTON_LEN) begin
          state_next.phase      = lia_pkg::PH_IDLE;
          state_next.kept_count = '0;
        end else begin
          state_next.kept_count = kept_inc;
        end
      end
      default: begin
        if (!in_text) begin
          state_next.phase      = lia_pkg::PH_BUTTON;
          state_next.kept_count = 7'd1;
        end else if (rx_byte == lia_pkg::CH_LF) begin
          state_next.phase      = lia_pkg::PH_IDLE;
          state_next.kept_count = '0;
        end else if (rx_byte == lia_pkg::CH_BS) begin
          state_next.phase      = lia_pkg::PH_TEXT;
          state_next.kept_count = (text_kept != '0) ? text_kept - 7'd1 : '0;
        end else begin
          state_next.phase      = lia_pkg::PH_TEXT;
          state_next.kept_count = (text_kept < eff_limit) ? text_kept + 7'd1 : text_kept;
        end
      end
    endcase
  end

  // result
  always_comb begin
    result = '0;
    unique case (state.phase)
      lia_pkg::PH_BUTTON: begin
        result.write_enable = 1'b1;
        result.write_index  = state.kept_count;
        result.write_data   = rx_byte;
        if (state.kept_count >= lia_pkg::BUTTON_LEN) begin
          result.message_done   = 1'b1;
          result.message_kind   = lia_pkg::KIND_BUTTON;
          result.message_length = lia_pkg::BUTTON_LEN;
        end
      end
      default: begin
        if (!in_text) begin
          result.write_enable = 1'b1;
          result.write_data   = rx_byte;
        end else if (rx_byte == lia_pkg::CH_LF) begin
          result.write_enable   = 1'b1;
          result.write_index    = text_kept;
          result.message_done   = 1'b1;
          result.message_kind   = lia_pkg::KIND_TEXT;
          result.message_length = text_kept;
        end else if (rx_byte == lia_pkg::CH_BS) begin
          result.echo_backspace = (text_kept != '0);
        end else if (text_kept < eff_limit) begin
          result.write_enable = 1'b1;
          result.write_index  = text_kept;
          result.write_data   = rx_byte;
        end
      end
    endcase
  end

endmodule

[rtl/lia_outbuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_outbuf: result register
// Holds one result; refills in the same cycle the held one is taken.
// ----------------------------------------------------------------------------
module lia_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  lia_pkg::lia_result_t load_data,
  output logic                 load_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lia_pkg::lia_result_t out_data
);

  assign load_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      out_data <= load_data;
    end
  end

endmodule

[rtl/line_input_assembler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_input_assembler_top: serial line / button packet assembler
// Turns received bytes into buffer write commands and message-done reports.
// ----------------------------------------------------------------------------
// Result: registered, out in the cycle after its byte is accepted.
// Throughput: 1 byte per cycle while results are taken; short decode
//   logic sits between the phase/count registers and the result register.
// Backpressure: a byte is taken while the result register is empty or drained.
// Reset (rst, synchronous): phase idle, count 0, line_limit 64, result empty.
// ----------------------------------------------------------------------------
module line_input_assembler_top #(
  parameter int unsigned BUF_DEPTH = lia_pkg::BUF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // line_limit write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,      // [6:0] line_limit
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  // write commands / message reports
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [lia_pkg::TDATA_W-1:0] m_axis_tdata,
                                     // [0] write_enable, [7:1] write_index,
                                     // [15:8] write_data, [16] echo_backspace,
                                     // [23:17] message_length
  output logic        m_axis_tlast,  // message_done
  output logic        m_axis_tuser   // message_kind (0 text, 1 button)
);

  localparam logic [lia_pkg::IDX_W-1:0] LIMIT_CAP = lia_pkg::limit_cap(BUF_DEPTH);

  lia_pkg::lia_state_t        state;
  lia_pkg::lia_state_t        state_next;
  lia_pkg::lia_result_t       step_result;
  lia_pkg::lia_result_t       res;
  logic [lia_pkg::IDX_W-1:0]  line_limit;
  logic                       in_accept;

  // Always ready; a new limit applies from the next byte on.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= lia_pkg::LINE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      line_limit <= cfg_data;
    end
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Phase and kept count advance on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= lia_pkg::PH_IDLE;
      state.kept_count <= '0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  lia_step #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_step (
    .state      (state),
    .line_limit (line_limit),
    .rx_byte    (s_axis_tdata),
    .state_next (state_next),
    .result     (step_result)
  );

  lia_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .load       (s_axis_tvalid),
    .load_data  (step_result),
    .load_ready (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (res)
  );

  // Pack the result; message_done and message_kind ride on tlast / tuser.
  assign m_axis_tdata = {res.message_length, res.echo_backspace, res.write_data,
                         res.write_index, res.write_enable};
  assign m_axis_tlast = res.message_done;
  assign m_axis_tuser = res.message_kind;

`ifndef SYNTH
  // Kept count can never pass the buffer-derived cap.
  a_kept_cap: assert property (@(posedge clk) disable iff (rst)
    state.kept_count <= LIMIT_CAP)
    else $error("kept_count above limit cap");

  // Inside a button packet the count stays within the packet body.
  a_button_count: assert property (@(posedge clk) disable iff (rst)
    state.phase == lia_pkg::PH_BUTTON |->
      (state.kept_count >= 7'd1 && state.kept_count <= lia_pkg::BUTTON_LEN))
    else $error("button packet count out of range");

  // A completed text line always writes its zero terminator.
  a_text_term: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.message_done && res.message_kind == lia_pkg::KIND_TEXT) |->
      (res.write_enable && res.write_data == '0 && res.write_index == res.message_length))
    else $error("text line completed without terminator");

  // A backspace echo never comes with a write or a completion.
  a_echo_alone: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.echo_backspace) |-> (!res.write_enable && !res.message_done))
    else $error("backspace echo combined with write");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for line_input_assembler_top
// Streams received bytes into the assembler, predicts every write command and
// message report in step with each accepted byte, and checks the result
// stream in order. The line limit is rewritten between phases, from zero up
// past the buffer depth. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DEPTH = lia_pkg::BUF_DEPTH_DEF;

  // --------------------------------------------------------------------------
  // DUT signals. Every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data      = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [0] write_enable, [7:1] write_index,
                                     // [15:8] write_data, [16] echo_backspace,
                                     // [23:17] message_length
  logic        m_axis_tlast;         // message_done
  logic        m_axis_tuser;         // message_kind

  line_input_assembler_top #(
    .BUF_DEPTH(DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  logic [7:0]           pending_bytes [$];   // bytes waiting for the driver
  lia_pkg::lia_result_t expected_cmds [$];   // predicted results, oldest first
  int          n_popped     = 0;    // bytes handed to the driver
  int          n_results    = 0;    // result transactions seen
  int          error_count  = 0;
  int          src_gap      = 0;
  int          snk_stall    = 0;
  bit          src_calm     = 1'b0; // calm stretches: no idling on that side
  bit          snk_calm     = 1'b0;

  // Predictor state, mirrors the assembler after reset.
  lia_pkg::lia_phase_t mdl_phase = lia_pkg::PH_IDLE;
  logic [6:0]          mdl_kept  = '0;
  logic [6:0]          mdl_limit = lia_pkg::LINE_LIMIT_RST;

  // Directed opening: button packet carrying LF/BS/extremes, BS as first
  // byte, echoed BS, empty line, '!' inside a text line, BS on an empty
  // line, extreme character values in a line.
  logic [7:0] directed_seq [0:20] = '{
    lia_pkg::CH_BANG, 8'h00, 8'hFF, lia_pkg::CH_LF, lia_pkg::CH_BS,
    lia_pkg::CH_BS, 8'h61, 8'h62, lia_pkg::CH_BS, lia_pkg::CH_LF,
    lia_pkg::CH_LF,
    8'h78, lia_pkg::CH_BANG, lia_pkg::CH_LF,
    8'h71, lia_pkg::CH_BS, lia_pkg::CH_BS, lia_pkg::CH_LF,
    8'hFF, 8'h00, lia_pkg::CH_LF
  };

  // --------------------------------------------------------------------------
  // Predictor: one byte in, one result out, updates phase/count.
  // --------------------------------------------------------------------------
  function automatic lia_pkg::lia_result_t assemble_byte(input logic [7:0] b);
    lia_pkg::lia_result_t r;
    logic [6:0]           lim;
    r   = '0;
    // limit in force never exceeds the buffer depth
    lim = (mdl_limit > 7'(DEPTH)) ? 7'(DEPTH) : mdl_limit;
    if (mdl_phase == lia_pkg::PH_BUTTON) begin
      // raw bytes, no decoding of LF/BS
      r.write_enable = 1'b1;
      r.write_index  = mdl_kept;
      r.write_data   = b;
      mdl_kept       = mdl_kept + 7'd1;
      if (mdl_kept >= lia_pkg::BUTTON_LEN + 7'd1) begin
        r.message_done   = 1'b1;
        r.message_kind   = lia_pkg::KIND_BUTTON;
        r.message_length = lia_pkg::BUTTON_LEN;
        mdl_phase        = lia_pkg::PH_IDLE;
        mdl_kept         = '0;
      end
    end else if (mdl_phase != lia_pkg::PH_TEXT && b == lia_pkg::CH_BANG) begin
      r.write_enable = 1'b1;
      r.write_index  = '0;
      r.write_data   = b;
      mdl_phase      = lia_pkg::PH_BUTTON;
      mdl_kept       = 7'd1;
    end else begin
      if (mdl_phase != lia_pkg::PH_TEXT) begin
        mdl_phase = lia_pkg::PH_TEXT;
        mdl_kept  = '0;
      end
      if (b == lia_pkg::CH_LF) begin
        // terminator goes right after the kept characters
        r.write_enable   = 1'b1;
        r.write_index    = mdl_kept;
        r.write_data     = 8'h00;
        r.message_done   = 1'b1;
        r.message_kind   = lia_pkg::KIND_TEXT;
        r.message_length = mdl_kept;
        mdl_phase        = lia_pkg::PH_IDLE;
        mdl_kept         = '0;
      end else if (b == lia_pkg::CH_BS) begin
        if (mdl_kept != 0) begin
          mdl_kept         = mdl_kept - 7'd1;
          r.echo_backspace = 1'b1;
        end
      end else if (mdl_kept < lim) begin
        r.write_enable = 1'b1;
        r.write_index  = mdl_kept;
        r.write_data   = b;
        mdl_kept       = mdl_kept + 7'd1;
      end
    end
    return r;
  endfunction

  function automatic string fmt_cmd(input lia_pkg::lia_result_t c);
    return $sformatf("we=%0d idx=%0d data=%02h echo=%0d done=%0d kind=%0d len=%0d",
                     c.write_enable, c.write_index, c.write_data, c.echo_backspace,
                     c.message_done, c.message_kind, c.message_length);
  endfunction

  task automatic log_failure(input string what);
    if (error_count < 10) begin
      $display("%0t: %s", $time, what);
    end
    error_count++;
  endtask

  // Idle/stall length for one transaction, drawn at random; none in a calm stretch.
  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // --------------------------------------------------------------------------
  // Byte driver. Predicts on every accepted transaction, then idles for the
  // drawn gap before presenting the next byte. tvalid gets one NBA per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    logic next_valid;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_cmds.push_back(assemble_byte(s_axis_tdata));
      end
      next_valid = s_axis_tvalid && !s_axis_tready;  // still waiting: hold
      if (!next_valid) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
        end else if (pending_bytes.size() != 0) begin
          s_axis_tdata <= pending_bytes.pop_front();
          next_valid   = 1'b1;
          n_popped++;
          if ($urandom_range(0, 39) == 0) begin
            src_calm = !src_calm;
          end
          src_gap <= draw_wait(src_calm);
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Checks each accepted transaction against the oldest
  // prediction, then stalls tready for the drawn number of cycles.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_cmds
    lia_pkg::lia_result_t got;
    lia_pkg::lia_result_t want;
    int                   stall;
    if (rst) begin
      m_axis_tready <= 1'b0;
      snk_stall     <= 0;
    end else begin
      stall = snk_stall;
      if (m_axis_tvalid && m_axis_tready) begin
        got.write_enable   = m_axis_tdata[0];
        got.write_index    = m_axis_tdata[7:1];
        got.write_data     = m_axis_tdata[15:8];
        got.echo_backspace = m_axis_tdata[16];
        got.message_length = m_axis_tdata[23:17];
        got.message_done   = m_axis_tlast;
        got.message_kind   = m_axis_tuser;
        n_results++;
        if (expected_cmds.size() == 0) begin
          log_failure({"unexpected result: ", fmt_cmd(got)});
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want) begin
            log_failure({"mismatch\n  expected ", fmt_cmd(want),
                         "\n  actual   ", fmt_cmd(got)});
          end
        end
        if ($urandom_range(0, 39) == 0) begin
          snk_calm = !snk_calm;
        end
        stall = draw_wait(snk_calm);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        snk_stall     <= stall - 1;
      end else begin
        m_axis_tready <= 1'b1;
        snk_stall     <= 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly whole messages with random content, some loose noise bytes.
  task automatic queue_random_messages(input int n_items);
    int         added;
    int         pick;
    int         len;
    int         lim;
    int         bs_pct;
    int         i;
    logic [7:0] ch;
    added = 0;
    lim   = (mdl_limit > DEPTH) ? DEPTH : mdl_limit;
    while (added < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // button packet: '!' plus four raw bytes
        pending_bytes.push_back(lia_pkg::CH_BANG);
        repeat (4) pending_bytes.push_back(8'($urandom_range(0, 255)));
        added += 5;
      end else if (pick < 88) begin
        // text line; some long enough to hit the limit
        if ($urandom_range(0, 4) == 0) begin
          len    = $urandom_range(0, lim + 8);
          bs_pct = ($urandom_range(0, 1) == 0) ? 0 : 10;
        end else begin
          len    = $urandom_range(0, 12);
          bs_pct = 10;
        end
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < bs_pct) begin
            ch = lia_pkg::CH_BS;
          end else begin
            ch = 8'($urandom_range(0, 255));
            if (ch == lia_pkg::CH_LF || (i == 0 && ch == lia_pkg::CH_BANG)) begin
              ch = 8'h41;  // keep the line whole
            end
          end
          pending_bytes.push_back(ch);
        end
        pending_bytes.push_back(lia_pkg::CH_LF);
        added += len + 1;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) pending_bytes.push_back(8'($urandom_range(0, 255)));
        added += len;
      end
    end
  endtask

  // Idle: nothing queued, every byte's result seen, then a short settle.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || n_results < n_popped) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_line_limit(input logic [6:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mdl_limit = value;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed bytes and random messages at the reset limit,
  // then one random phase per limit setting, each written while the assembler is idle.
  // --------------------------------------------------------------------------
  initial begin : run_phases
    int         k;
    logic [6:0] lim;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_seq[j]) begin
      pending_bytes.push_back(directed_seq[j]);
    end
    queue_random_messages(175);
    wait_idle();

    // zero, above buffer depth (max), one, small, just above depth, depth,
    // just below depth, then random settings
    for (k = 0; k < 9; k++) begin
      case (k)
        0:       lim = 7'd0;
        1:       lim = lia_pkg::IDX_MAX;
        2:       lim = 7'd1;
        3:       lim = 7'd5;
        4:       lim = 7'd65;
        5:       lim = 7'd64;
        6:       lim = 7'd63;
        default: lim = 7'($urandom_range(0, 127));
      endcase
      write_line_limit(lim);
      queue_random_messages(175);
      wait_idle();
    end

    if (expected_cmds.size() != 0) begin
      log_failure($sformatf("%0d expected results never arrived", expected_cmds.size()));
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/lia_pkg.sv
rtl/lia_step.sv
rtl/lia_outbuf.sv
rtl/line_input_assembler_top.sv
tb/tb.sv
